/* sv/cabb_pkg.sv */
// shared types and constants of the clipped alpha blend blit
// no dependencies
`default_nettype none

package cabb_pkg;

   localparam int SCREEN_WIDTH_DEF  = 1024;
   localparam int SCREEN_HEIGHT_DEF = 768;

   localparam logic [7:0] ALPHA_MAX = 8'd255;

   localparam int CSR_ADDR_WIDTH = 5;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_CLIP_LEFT   = 3'd2,
      CSR_CLIP_TOP    = 3'd3,
      CSR_CLIP_WIDTH  = 3'd4,
      CSR_CLIP_HEIGHT = 3'd5,
      CSR_IMAGE_WIDTH = 3'd6
   } csr_index_type;

   localparam logic [12:0] ORIGIN_X_RST    = 13'd0;
   localparam logic [12:0] ORIGIN_Y_RST    = 13'd0;
   localparam logic [11:0] CLIP_LEFT_RST   = 12'd0;
   localparam logic [11:0] CLIP_TOP_RST    = 12'd0;
   localparam logic [12:0] CLIP_WIDTH_RST  = 13'd4096;
   localparam logic [12:0] CLIP_HEIGHT_RST = 13'd4096;
   localparam logic [12:0] IMAGE_WIDTH_RST = 13'd1;

   typedef struct packed {
      logic signed [12:0] origin_x;
      logic signed [12:0] origin_y;
      logic [11:0]        clip_left;
      logic [11:0]        clip_top;
      logic [12:0]        clip_width;
      logic [12:0]        clip_height;
      logic [12:0]        image_width;
   } cfg_type;

   // screen position of one pixel and its write decision
   typedef struct packed {
      logic signed [13:0] screen_x;
      logic signed [13:0] screen_y;
      logic               write_enable;
   } pos_type;

endpackage

`default_nettype wire

/* sv/cabb_csr.sv */
// configuration register file on an apb-style port
// depends on cabb_pkg
`default_nettype none

module cabb_csr
   import cabb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic      [31:0]               csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_pwdata[12:0];
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_pwdata[12:0];
            CSR_CLIP_LEFT:   cfg_in.clip_left   = csr_pwdata[11:0];
            CSR_CLIP_TOP:    cfg_in.clip_top    = csr_pwdata[11:0];
            CSR_CLIP_WIDTH:  cfg_in.clip_width  = csr_pwdata[12:0];
            CSR_CLIP_HEIGHT: cfg_in.clip_height = csr_pwdata[12:0];
            CSR_IMAGE_WIDTH: cfg_in.image_width = csr_pwdata[12:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_ORIGIN_X:    csr_prdata = {19'd0, cfg_ff.origin_x};
         CSR_ORIGIN_Y:    csr_prdata = {19'd0, cfg_ff.origin_y};
         CSR_CLIP_LEFT:   csr_prdata = {20'd0, cfg_ff.clip_left};
         CSR_CLIP_TOP:    csr_prdata = {20'd0, cfg_ff.clip_top};
         CSR_CLIP_WIDTH:  csr_prdata = {19'd0, cfg_ff.clip_width};
         CSR_CLIP_HEIGHT: csr_prdata = {19'd0, cfg_ff.clip_height};
         CSR_IMAGE_WIDTH: csr_prdata = {19'd0, cfg_ff.image_width};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= ORIGIN_X_RST;
         cfg_ff.origin_y    <= ORIGIN_Y_RST;
         cfg_ff.clip_left   <= CLIP_LEFT_RST;
         cfg_ff.clip_top    <= CLIP_TOP_RST;
         cfg_ff.clip_width  <= CLIP_WIDTH_RST;
         cfg_ff.clip_height <= CLIP_HEIGHT_RST;
         cfg_ff.image_width <= IMAGE_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* sv/cabb_scan.sv */
// column and row counters, screen position and screen/clip test
// depends on cabb_pkg
`default_nettype none

module cabb_scan
   import cabb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    advance,
   output pos_type      pos
);

   localparam logic [13:0] SCR_W = 14'(SCREEN_WIDTH);
   localparam logic [13:0] SCR_H = 14'(SCREEN_HEIGHT);

   logic [11:0] column_count_ff;
   logic [11:0] column_count_in;
   logic [11:0] row_count_ff;
   logic [11:0] row_count_in;
   logic [12:0] column_next;
   logic        row_wrap;
   logic [13:0] x_val;
   logic [13:0] y_val;
   logic [13:0] clip_right;
   logic [13:0] clip_bottom;
   logic        on_screen;
   logic        in_clip;

   // position is origin plus count; negative values fail the on-screen test below
   assign x_val = {cfg.origin_x[12], cfg.origin_x} + {2'b00, column_count_ff};
   assign y_val = {cfg.origin_y[12], cfg.origin_y} + {2'b00, row_count_ff};

   assign clip_right  = {2'b00, cfg.clip_left} + {1'b0, cfg.clip_width};
   assign clip_bottom = {2'b00, cfg.clip_top}  + {1'b0, cfg.clip_height};

   assign on_screen = !x_val[13] && !y_val[13] && (x_val < SCR_W) && (y_val < SCR_H);
   assign in_clip   = (x_val >= {2'b00, cfg.clip_left}) && (x_val < clip_right) &&
                      (y_val >= {2'b00, cfg.clip_top})  && (y_val < clip_bottom);

   assign pos.screen_x     = x_val;
   assign pos.screen_y     = y_val;
   assign pos.write_enable = on_screen && in_clip;

   // zero width wraps every pixel; a full 12-bit count wraps regardless of width
   assign column_next = {1'b0, column_count_ff} + 13'd1;
   assign row_wrap    = (column_next >= cfg.image_width) || (column_count_ff == 12'hFFF);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (advance) begin
         if (row_wrap) begin
            column_count_in = 12'd0;
            row_count_in    = row_count_ff + 12'd1;
         end else begin
            column_count_in = column_next[11:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 12'd0;
         row_count_ff    <= 12'd0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (column_count_ff == 12'd0) ||
                  (column_count_ff == $past(column_count_ff) + 12'd1))
      else $error("column counter skipped");

   a_row_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(row_count_ff) && $stable(column_count_ff))
      else $error("counters moved without a request");

endmodule

`default_nettype wire

/* sv/cabb_blend.sv */
// one channel of the truncating source-over blend
// depends on cabb_pkg
`default_nettype none

module cabb_blend
   import cabb_pkg::*;
(
   input  wire logic [7:0] dst,
   input  wire logic [7:0] src,
   input  wire logic [7:0] alpha,
   output logic      [7:0] blended
);

   logic [15:0] dst_part;
   logic [15:0] src_part;
   logic [15:0] sum;
   logic [16:0] scaled;

   assign dst_part = dst * (ALPHA_MAX - alpha);
   assign src_part = src * alpha;
   // sum is at most 255*255, so it fits 16 bits
   assign sum      = dst_part + src_part;
   // divide by 255: (v + 1 + v/256) / 256 is exact below 65535
   assign scaled   = {1'b0, sum} + 17'd1 + {9'd0, sum[15:8]};
   assign blended  = scaled[15:8];

endmodule

`default_nettype wire

/* sv/clipped_alpha_blend_blit.sv */
// top level of the clipped alpha blend blit: stream ports, csr port, two-register pipe
// depends on cabb_pkg, cabb_csr, cabb_scan, cabb_blend
`default_nettype none

// Blends a stream of source RGBA pixels over destination RGB pixels, one
// request per clock. Source pixels arrive in row order for an image of
// image_width columns whose top-left corner sits at (origin_x, origin_y); an
// internal column/row counter gives each request its screen position. A pixel
// is written (rsp_tuser high) only when it lies on the SCREEN_WIDTH x
// SCREEN_HEIGHT screen and inside the clip rectangle, whose right and bottom
// edges are exclusive; otherwise the color fields are zero. The blend is
// (dst*(255-a) + src*a)/255 truncated, per channel. Each request passes an
// input register (position and clip decision latched with it) and then a
// result register holding the blend; a new request is taken every cycle as
// long as the result side keeps up. While the result register is stalled
// the input register holds its request, and with both registers full
// req_tready follows rsp_tready in the same cycle. The column counter returns
// to zero at each row end and on reset, the row counter only on reset or
// overflow: start every image after a reset or after a whole number of rows.
// Change registers only while the pipe is empty.

module clipped_alpha_blend_blit
   import cabb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request: src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [55:0]               req_tdata,
   // response: out_red, out_green, out_blue, screen_x[37:24], screen_y[51:38], zero fill
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [55:0]               rsp_tdata,
   // response: write_enable
   output logic                           rsp_tuser,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   output logic      [31:0]               csr_prdata,
   output logic                           csr_pready
);

   cfg_type cfg;
   pos_type pos;

   logic req_accept;
   logic s2_load;

   // input register
   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [55:0] s1_data_ff;
   pos_type     s1_pos_ff;

   // result register
   logic        s2_valid_ff;
   logic        s2_valid_in;
   logic [7:0]  red_ff;
   logic [7:0]  green_ff;
   logic [7:0]  blue_ff;
   pos_type     s2_pos_ff;

   logic [7:0]  red_mix;
   logic [7:0]  green_mix;
   logic [7:0]  blue_mix;

   cabb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cabb_scan #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (req_accept),
      .pos     (pos)
   );

   // result register loads when stage one is full and the result slot frees up
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_accept = req_tvalid && req_tready;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_tready);

   cabb_blend u_blend_red (
      .dst     (s1_data_ff[39:32]),
      .src     (s1_data_ff[7:0]),
      .alpha   (s1_data_ff[31:24]),
      .blended (red_mix)
   );

   cabb_blend u_blend_green (
      .dst     (s1_data_ff[47:40]),
      .src     (s1_data_ff[15:8]),
      .alpha   (s1_data_ff[31:24]),
      .blended (green_mix)
   );

   cabb_blend u_blend_blue (
      .dst     (s1_data_ff[55:48]),
      .src     (s1_data_ff[23:16]),
      .alpha   (s1_data_ff[31:24]),
      .blended (blue_mix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_tdata;
         s1_pos_ff  <= pos;
      end
      if (s2_load) begin
         // masked pixels carry zero color
         red_ff    <= s1_pos_ff.write_enable ? red_mix   : 8'd0;
         green_ff  <= s1_pos_ff.write_enable ? green_mix : 8'd0;
         blue_ff   <= s1_pos_ff.write_enable ? blue_mix  : 8'd0;
         s2_pos_ff <= s1_pos_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tuser  = s2_pos_ff.write_enable;
   assign rsp_tdata  = {4'd0, s2_pos_ff.screen_y, s2_pos_ff.screen_x,
                        blue_ff, green_ff, red_ff};

   a_masked_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[23:0] == 24'd0))
      else $error("masked pixel carries color");

   a_write_on_screen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (!rsp_tdata[37] && !rsp_tdata[51]))
      else $error("write enabled at a negative position");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> s1_valid_ff)
      else $error("stalled request lost from input register");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty pipe refuses requests");

endmodule

`default_nettype wire
